@@ rtl/core/ibse_pkg.sv @@
// Package for the indexed bit and shift executor.
// Holds flag positions, opcode group codes, cycle counts and the word types.
// Depends on nothing; every module of the block imports it.
package ibse_pkg;

	localparam int unsigned FlagS = 7;
	localparam int unsigned FlagZ = 6;
	localparam int unsigned FlagH = 4;
	localparam int unsigned FlagP = 2;
	localparam int unsigned FlagN = 1;
	localparam int unsigned FlagC = 0;

	localparam logic [4:0] CYC_BIT  = 5'd20;
	localparam logic [4:0] CYC_RMW  = 5'd23;
	localparam logic [4:0] CYC_TRAP = 5'd0;

	localparam logic [2:0] OP_LOW_INDEXED = 3'd6;
	localparam logic [7:0] OP_SLL_IND     = 8'h36;

	typedef enum logic [1:0] {
		GRP_SHIFT = 2'd0,
		GRP_BIT   = 2'd1,
		GRP_RES   = 2'd2,
		GRP_SET   = 2'd3
	} grp_t;

	typedef enum logic [2:0] {
		SH_RLC = 3'd0,
		SH_RRC = 3'd1,
		SH_RL  = 3'd2,
		SH_RR  = 3'd3,
		SH_SLA = 3'd4,
		SH_SRA = 3'd5,
		SH_SLL = 3'd6,
		SH_SRL = 3'd7
	} shift_t;

	typedef struct packed {
		logic [7:0]        opcode;
		logic signed [7:0] displacement;
		logic [15:0]       index_base;
		logic [7:0]        operand_byte;
		logic [7:0]        flags_in;
	} ibse_word_in_t;

	typedef struct packed {
		logic [15:0] effective_address;
		logic        write_enable;
		logic [7:0]  result_byte;
		logic [7:0]  flags_out;
		logic [4:0]  cycle_count;
		logic        trap;
	} ibse_word_out_t;

endpackage

@@ rtl/core/ibse_exec.sv @@
// Combinational execute logic for one indexed bit or shift instruction.
// Computes address, write-back, flags, cycle count and trap from one word.
// Depends on ibse_pkg.
module ibse_exec import ibse_pkg::*; (
	input  ibse_word_in_t  word_in,
	output ibse_word_out_t word_out
);

	logic [7:0]  val;
	logic [7:0]  fin;
	logic [7:0]  mask;
	logic [7:0]  shifted;
	logic        carry;
	logic [7:0]  res;
	logic [7:0]  fout;
	logic        we;
	logic [4:0]  cyc;
	logic        trap;
	grp_t        grp;
	shift_t      sh;

	always_comb begin
		val  = word_in.operand_byte;
		fin  = word_in.flags_in;
		grp  = grp_t'(word_in.opcode[7:6]);
		sh   = shift_t'(word_in.opcode[5:3]);
		mask = 8'd1 << word_in.opcode[5:3];
		trap = (word_in.opcode[2:0] != OP_LOW_INDEXED) || (word_in.opcode == OP_SLL_IND);

		unique case (sh)
			SH_RLC: begin
				carry   = val[7];
				shifted = {val[6:0], val[7]};
			end
			SH_RRC: begin
				carry   = val[0];
				shifted = {val[0], val[7:1]};
			end
			SH_RL: begin
				carry   = val[7];
				shifted = {val[6:0], fin[FlagC]};
			end
			SH_RR: begin
				carry   = val[0];
				shifted = {fin[FlagC], val[7:1]};
			end
			SH_SLA: begin
				carry   = val[7];
				shifted = {val[6:0], 1'b0};
			end
			SH_SRA: begin
				carry   = val[0];
				shifted = {val[7], val[7:1]};
			end
			SH_SLL, SH_SRL: begin
				carry   = val[0];
				shifted = {1'b0, val[7:1]};
			end
			default: begin
				carry   = 1'b0;
				shifted = 8'd0;
			end
		endcase

		res  = 8'd0;
		fout = fin;
		we   = 1'b0;
		cyc  = CYC_TRAP;
		if (!trap) begin
			unique case (grp)
				GRP_SHIFT: begin
					res         = shifted;
					fout[FlagS] = shifted[7];
					fout[FlagZ] = (shifted == 8'd0);
					fout[FlagH] = 1'b0;
					fout[FlagP] = ~^shifted;
					fout[FlagN] = 1'b0;
					fout[FlagC] = carry;
					we          = 1'b1;
					cyc         = CYC_RMW;
				end
				GRP_BIT: begin
					fout[FlagH] = 1'b1;
					fout[FlagN] = 1'b0;
					fout[FlagZ] = ((val & mask) == 8'd0);
					fout[FlagP] = ((val & mask) == 8'd0);
					fout[FlagS] = (sh == SH_SRL) && val[7];
					cyc         = CYC_BIT;
				end
				GRP_RES: begin
					res = val & ~mask;
					we  = 1'b1;
					cyc = CYC_RMW;
				end
				GRP_SET: begin
					res = val | mask;
					we  = 1'b1;
					cyc = CYC_RMW;
				end
				default: begin
					res = 8'd0;
				end
			endcase
		end

		word_out.effective_address = word_in.index_base
			+ {{8{word_in.displacement[7]}}, word_in.displacement};
		word_out.write_enable = we;
		word_out.result_byte  = res;
		word_out.flags_out    = fout;
		word_out.cycle_count  = cyc;
		word_out.trap         = trap;
	end

endmodule

@@ rtl/core/indexed_bit_shift_execute.sv @@
// Top level of the indexed bit and shift executor.
// Input register, execute logic (ibse_exec) and result register.
// Depends on ibse_pkg and ibse_exec.

// Each input word is captured in the input register, decoded and executed by
// ibse_exec, and its result is captured in the result register, which drives
// the output. One word is accepted every cycle while the output side takes
// results; when the output is held, each register stage stalls only once it
// is full, so no word is lost while a result waits.
module indexed_bit_shift_execute import ibse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        opcode,
	input  logic signed [7:0] displacement,
	input  logic [15:0]       index_base,
	input  logic [7:0]        operand_byte,
	input  logic [7:0]        flags_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       effective_address,
	output logic              write_enable,
	output logic [7:0]        result_byte,
	output logic [7:0]        flags_out,
	output logic [4:0]        cycle_count,
	output logic              trap
);

	logic           valid_s1;
	logic           valid_s2;
	ibse_word_in_t  word_s1;
	ibse_word_out_t word_s2;
	ibse_word_out_t exec_out;
	logic           adv_s2;
	logic           adv_s1;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	ibse_exec u_exec (
		.word_in  (word_s1),
		.word_out (exec_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1.opcode       <= opcode;
			word_s1.displacement <= displacement;
			word_s1.index_base   <= index_base;
			word_s1.operand_byte <= operand_byte;
			word_s1.flags_in     <= flags_in;
		end
		if (adv_s2 && valid_s1) begin
			word_s2 <= exec_out;
		end
	end

	assign out_valid         = valid_s2;
	assign effective_address = word_s2.effective_address;
	assign write_enable      = word_s2.write_enable;
	assign result_byte       = word_s2.result_byte;
	assign flags_out         = word_s2.flags_out;
	assign cycle_count       = word_s2.cycle_count;
	assign trap              = word_s2.trap;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("executed word did not reach the result register");

	a_write_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_enable) |-> (!trap && cycle_count == CYC_RMW))
		else $error("write-back word has wrong cycle count or trap");

endmodule

@@ dv/indexed_bit_shift_execute_checker.sv @@
// Checker for the indexed bit and shift executor: watches both channels,
// predicts each result from the accepted word and compares it field by field.
// Depends on ibse_pkg for the word types, flag positions and opcode codes.
module indexed_bit_shift_execute_checker import ibse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        opcode,
	input  logic signed [7:0] displacement,
	input  logic [15:0]       index_base,
	input  logic [7:0]        operand_byte,
	input  logic [7:0]        flags_in,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [15:0]       effective_address,
	input  logic              write_enable,
	input  logic [7:0]        result_byte,
	input  logic [7:0]        flags_out,
	input  logic [4:0]        cycle_count,
	input  logic              trap,
	output int                mismatch_count,
	output int                words_in_flight
);

	timeunit 1ns;
	timeprecision 1ps;

	ibse_word_out_t expected_results[$];
	ibse_word_in_t  taken_word;
	ibse_word_out_t predicted;
	ibse_word_out_t oldest;
	int             mismatches = 0;
	int             pending    = 0;

	assign mismatch_count  = mismatches;
	assign words_in_flight = pending;

	function automatic ibse_word_out_t execute_indexed_op(ibse_word_in_t w);
		ibse_word_out_t r;
		logic [2:0]     sel;
		logic [7:0]     f;
		logic [7:0]     v;
		logic [7:0]     res;
		logic           carry;
		r     = '0;
		sel   = w.opcode[5:3];
		f     = w.flags_in;
		v     = w.operand_byte;
		res   = '0;
		carry = 1'b0;
		r.effective_address = w.index_base + {{8{w.displacement[7]}}, w.displacement};
		if (w.opcode[2:0] != OP_LOW_INDEXED || w.opcode == OP_SLL_IND) begin
			r.trap        = 1'b1;
			r.cycle_count = CYC_TRAP;
		end else begin
			case (grp_t'(w.opcode[7:6]))
				GRP_SHIFT: begin
					case (shift_t'(sel))
						SH_RLC: begin carry = v[7]; res = {v[6:0], v[7]}; end
						SH_RRC: begin carry = v[0]; res = {v[0], v[7:1]}; end
						SH_RL:  begin carry = v[7]; res = {v[6:0], f[FlagC]}; end
						SH_RR:  begin carry = v[0]; res = {f[FlagC], v[7:1]}; end
						SH_SLA: begin carry = v[7]; res = {v[6:0], 1'b0}; end
						SH_SRA: begin carry = v[0]; res = {v[7], v[7:1]}; end
						default: begin carry = v[0]; res = {1'b0, v[7:1]}; end
					endcase
					f[FlagS] = res[7];
					f[FlagZ] = (res == 8'h00);
					f[FlagH] = 1'b0;
					f[FlagP] = ~^res;
					f[FlagN] = 1'b0;
					f[FlagC] = carry;
					r.write_enable = 1'b1;
					r.cycle_count  = CYC_RMW;
				end
				GRP_BIT: begin
					f[FlagN] = 1'b0;
					f[FlagH] = 1'b1;
					f[FlagZ] = ~v[sel];
					f[FlagP] = ~v[sel];
					f[FlagS] = (sel == 3'd7) && v[sel];
					r.cycle_count = CYC_BIT;
				end
				GRP_RES: begin
					res = v & ~(8'h01 << sel);
					r.write_enable = 1'b1;
					r.cycle_count  = CYC_RMW;
				end
				default: begin
					res = v | (8'h01 << sel);
					r.write_enable = 1'b1;
					r.cycle_count  = CYC_RMW;
				end
			endcase
		end
		r.result_byte = res;
		r.flags_out   = f;
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word, expected none, actual ea %h res %h",
						$time, effective_address, result_byte);
				end else begin
					oldest = expected_results.pop_front();
					check_field("effective_address", oldest.effective_address,
						effective_address);
					check_field("write_enable", 16'(oldest.write_enable), 16'(write_enable));
					check_field("result_byte", 16'(oldest.result_byte), 16'(result_byte));
					check_field("flags_out", 16'(oldest.flags_out), 16'(flags_out));
					check_field("cycle_count", 16'(oldest.cycle_count), 16'(cycle_count));
					check_field("trap", 16'(oldest.trap), 16'(trap));
				end
			end
			if (in_valid && in_ready) begin
				taken_word = '{opcode, displacement, index_base, operand_byte, flags_in};
				predicted  = execute_indexed_op(taken_word);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ dv/indexed_bit_shift_execute_tb.sv @@
// Top of the testbench for the indexed bit and shift executor.
// Drives directed and random words with varying idle patterns and gives the verdict.
// Depends on ibse_pkg, the block itself and indexed_bit_shift_execute_checker.
module indexed_bit_shift_execute_tb import ibse_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomWords = 1150;
	localparam int LongHold    = 80;
	localparam int TickLimit   = 200000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [7:0]        opcode       = '0;
	logic signed [7:0] displacement = '0;
	logic [15:0]       index_base   = '0;
	logic [7:0]        operand_byte = '0;
	logic [7:0]        flags_in     = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [15:0]       effective_address;
	logic              write_enable;
	logic [7:0]        result_byte;
	logic [7:0]        flags_out;
	logic [4:0]        cycle_count;
	logic              trap;

	int mismatch_count;
	int words_in_flight;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int holds_asked   = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int clock_ticks   = 0;

	indexed_bit_shift_execute u_dut (.*);

	indexed_bit_shift_execute_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		clock_ticks++;
		if (clock_ticks > TickLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls at random, or for a long stretch when one is asked for.
	initial begin
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left    = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_word(logic [7:0] op, logic signed [7:0] disp, logic [15:0] base,
			logic [7:0] val, logic [7:0] flags);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		displacement <= disp;
		index_base   <= base;
		operand_byte <= val;
		flags_in     <= flags;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_op(grp_t grp, logic [2:0] sel, logic signed [7:0] disp,
			logic [15:0] base, logic [7:0] val, logic [7:0] flags);
		send_word({grp, sel, OP_LOW_INDEXED}, disp, base, val, flags);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_in_flight != 0)
			@(negedge clk);
	endtask

	task automatic send_random_word();
		logic [7:0]        op;
		logic signed [7:0] disp;
		logic [15:0]       base;
		logic [7:0]        val;
		if ($urandom_range(99) < 12) begin
			op = 8'($urandom_range(255));
		end else begin
			op = {2'($urandom_range(3)), 3'($urandom_range(7)), OP_LOW_INDEXED};
			if (op == OP_SLL_IND)
				op = {GRP_SHIFT, SH_SRL, OP_LOW_INDEXED};
		end
		disp = 8'($urandom_range(255));
		case ($urandom_range(9))
			0:       base = 16'hFFFF;
			1:       base = 16'h0000;
			default: base = 16'($urandom);
		endcase
		case ($urandom_range(7))
			0:       val = 8'h00;
			1:       val = 8'hFF;
			default: val = 8'($urandom_range(255));
		endcase
		send_word(op, disp, base, val, 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_op(GRP_SHIFT, SH_RLC, 8'sd127, 16'hFFFF, 8'h80, 8'h00);
		send_op(GRP_SHIFT, SH_RRC, -8'sd128, 16'h0000, 8'h01, 8'hFF);
		send_op(GRP_SHIFT, SH_RL, 8'sd0, 16'h1234, 8'h00, 8'h01);
		send_op(GRP_SHIFT, SH_RL, -8'sd1, 16'h8000, 8'h80, 8'h00);
		send_op(GRP_SHIFT, SH_RR, 8'sd1, 16'h7FFF, 8'h01, 8'h01);
		send_op(GRP_SHIFT, SH_SLA, 8'sd5, 16'h4000, 8'hFF, 8'hFF);
		send_op(GRP_SHIFT, SH_SRA, -8'sd5, 16'h0004, 8'h81, 8'h28);
		send_op(GRP_SHIFT, SH_SRL, 8'sd64, 16'hFFC0, 8'h01, 8'hD7);
		send_op(GRP_SHIFT, SH_RLC, 8'sd0, 16'h0100, 8'h00, 8'hFF);
		send_op(GRP_BIT, 3'd0, 8'sd3, 16'h2000, 8'hFE, 8'hFF);
		send_op(GRP_BIT, 3'd0, -8'sd3, 16'h2000, 8'h01, 8'h00);
		send_op(GRP_BIT, 3'd7, 8'sd127, 16'hFF80, 8'h80, 8'h00);
		send_op(GRP_BIT, 3'd7, -8'sd128, 16'h0080, 8'h7F, 8'hFF);
		send_op(GRP_BIT, 3'd3, 8'sd10, 16'h5555, 8'hFF, 8'h01);
		send_op(GRP_RES, 3'd0, 8'sd0, 16'hAAAA, 8'hFF, 8'hFF);
		send_op(GRP_RES, 3'd7, 8'sd1, 16'hFFFF, 8'hFF, 8'h00);
		send_op(GRP_SET, 3'd0, -8'sd1, 16'h0000, 8'h00, 8'h00);
		send_op(GRP_SET, 3'd7, 8'sd2, 16'h0001, 8'h00, 8'hFF);
		send_word(OP_SLL_IND, 8'sd4, 16'h1000, 8'h55, 8'hA5);
		send_word({GRP_SHIFT, SH_RLC, 3'd0}, -8'sd128, 16'h0000, 8'hFF, 8'h5A);
		send_word({GRP_SET, 3'd7, 3'd7}, 8'sd127, 16'hFFFF, 8'h00, 8'hFF);
		send_word({GRP_SET, 3'd1, 3'd3}, 8'sd0, 16'hBEEF, 8'h3C, 8'h00);
		drain_results();

		tx_idle_pct = 16;
		rx_idle_pct = 61;
		for (int i = 0; i < RandomWords / 3; i++) begin
			if (i == 100)
				holds_asked++;
			send_random_word();
		end
		drain_results();

		tx_idle_pct = 61;
		rx_idle_pct = 16;
		for (int i = 0; i < RandomWords / 3; i++)
			send_random_word();
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < RandomWords - 2 * (RandomWords / 3); i++) begin
			if (i == 50)
				holds_asked++;
			send_random_word();
		end
		drain_results();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
